/* rtl/vps_pkg.sv */
// package: shared types, operation codes and wait tables for the vibration pattern sequencer
package vps_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned SelW  = 2;
  localparam int unsigned StepW = 3;
  localparam int unsigned WaitW = 10;

  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef logic [SelW-1:0]  sel_t;
  typedef logic [StepW-1:0] step_t;
  typedef logic [WaitW-1:0] wait_t;

  typedef struct packed {
    logic  playing;
    logic  looping;
    sel_t  pattern;
    step_t step;
    logic  level;
    wait_t wait_left;
  } play_state_t;

  localparam play_state_t StateReset = '{
    playing: 1'b0, looping: 1'b0, pattern: '0, step: '0, level: 1'b0, wait_left: '0
  };

  localparam sel_t  PatOne  = 2'd1;
  localparam sel_t  PatTwo  = 2'd2;
  localparam step_t LenZero = 3'd4;
  localparam step_t LenOne  = 3'd6;
  localparam step_t LenTwo  = 3'd2;

  function automatic step_t table_len(input sel_t sel);
    step_t len;
    case (sel)
      PatOne:  len = LenOne;
      PatTwo:  len = LenTwo;
      default: len = LenZero;
    endcase
    return len;
  endfunction

  function automatic wait_t table_wait(input sel_t sel, input step_t idx);
    wait_t w;
    w = '0;
    case (sel)
      PatOne: begin
        case (idx)
          3'd0:    w = 10'd400;
          3'd1:    w = 10'd200;
          3'd2:    w = 10'd400;
          3'd3:    w = 10'd200;
          3'd4:    w = 10'd400;
          3'd5:    w = 10'd800;
          default: w = '0;
        endcase
      end
      PatTwo: begin
        case (idx)
          3'd0:    w = 10'd400;
          3'd1:    w = 10'd400;
          3'd2:    w = 10'd400;
          3'd3:    w = 10'd800;
          default: w = '0;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    w = 10'd200;
          3'd1:    w = 10'd200;
          3'd2:    w = 10'd200;
          3'd3:    w = 10'd800;
          default: w = '0;
        endcase
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/vps_if.sv */
// interfaces: command and status channels with valid/ready handshake
interface vps_cmd_if;
  import vps_pkg::*;
  logic   valid;
  logic   ready;
  logic [OpW-1:0]  operation;
  logic [SelW-1:0] pattern_select;
  logic   repeat_mode;

  modport source (output valid, output operation, output pattern_select,
                  output repeat_mode, input ready);
  modport sink   (input valid, input operation, input pattern_select,
                  input repeat_mode, output ready);
endinterface

interface vps_rsp_if;
  import vps_pkg::*;
  logic   valid;
  logic   ready;
  logic   motor_on;
  logic   pattern_active;
  logic [StepW-1:0] step_number;

  modport source (output valid, output motor_on, output pattern_active,
                  output step_number, input ready);
  modport sink   (input valid, input motor_on, input pattern_active,
                  input step_number, output ready);
endinterface

/* rtl/vps_step.sv */
// next-state logic: applies one tick, start or stop beat to the player state
module vps_step (
  input  vps_pkg::play_state_t cur,
  input  vps_pkg::op_t         op,
  input  vps_pkg::sel_t        sel,
  input  logic                 rep,
  output vps_pkg::play_state_t nxt
);
  import vps_pkg::*;

  wait_t dec_wait;
  step_t inc_step;
  wait_t fire_wait;
  wait_t first_wait;
  logic  at_end;

  assign dec_wait   = (cur.wait_left != '0) ? cur.wait_left - 1'b1 : '0;
  assign inc_step   = cur.step + 1'b1;
  assign fire_wait  = table_wait(cur.pattern, cur.step);
  assign first_wait = table_wait(cur.pattern, '0);
  assign at_end     = (inc_step >= table_len(cur.pattern));

  always_comb begin
    nxt = cur;
    case (op)
      OP_START: begin
        nxt.playing   = 1'b1;
        nxt.looping   = rep;
        nxt.pattern   = sel;
        nxt.step      = '0;
        nxt.level     = 1'b1;
        nxt.wait_left = '0;
      end
      OP_STOP: begin
        nxt.playing = 1'b0;
        nxt.level   = 1'b0;
      end
      OP_TICK: begin
        if (cur.playing) begin
          nxt.wait_left = dec_wait;
          if (dec_wait == '0) begin
            if (!at_end) begin
              nxt.level     = ~cur.level;
              nxt.wait_left = fire_wait;
              nxt.step      = inc_step;
            end else if (cur.looping) begin
              nxt.level     = 1'b1;
              nxt.wait_left = first_wait;
              nxt.step      = '0;
            end else begin
              nxt.playing   = 1'b0;
              nxt.level     = 1'b0;
              nxt.wait_left = fire_wait;
              nxt.step      = inc_step;
            end
          end
        end
      end
      default: nxt = cur;
    endcase
  end

endmodule

/* rtl/vibration_pattern_sequencer_core.sv */
// top level: vibration pattern sequencer with input register, state and result register
// Usage:
//   cmd carries one beat per item: operation (tick, start, stop), pattern_select
//   and repeat_mode. Each accepted beat yields exactly one beat on rsp with
//   motor_on, pattern_active and step_number as they stand after that item.
//   A tick stands for one millisecond of the pattern clock.
// Path: an accepted beat lands in the input register; its result is registered
//   in the result register once that register is free.
// Throughput: one beat per cycle while rsp is not held off; the state update
//   between the input register and the result register is combinational.
// Stall: while rsp is held off, the result register keeps its beat, the input
//   register holds one more and cmd.ready drops; nothing is dropped or repeated.
// Reset: rst is synchronous, active high; it empties both registers and clears
//   the player state (motor off, idle, step 0, pattern 0, wait 0).
module vibration_pattern_sequencer_core (
  input logic   clk,
  input logic   rst,
  vps_cmd_if.sink   cmd,
  vps_rsp_if.source rsp
);
  import vps_pkg::*;

  logic        s1_valid;
  op_t         s1_op;
  sel_t        s1_sel;
  logic        s1_rep;
  play_state_t state;
  play_state_t state_next;
  logic        rsp_valid;
  logic        rsp_motor;
  logic        rsp_active;
  step_t       rsp_step;
  logic        out_free;
  logic        s1_adv;
  logic        cmd_take;

  assign out_free  = !rsp_valid || rsp.ready;
  assign s1_adv    = s1_valid && out_free;
  assign cmd.ready = !s1_valid || out_free;
  assign cmd_take  = cmd.valid && cmd.ready;

  vps_step u_step (
    .cur (state),
    .op  (s1_op),
    .sel (s1_sel),
    .rep (s1_rep),
    .nxt (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s1_op  <= op_t'(cmd.operation);
      s1_sel <= cmd.pattern_select;
      s1_rep <= cmd.repeat_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StateReset;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp_motor  <= state_next.level;
      rsp_active <= state_next.playing;
      rsp_step   <= state_next.step;
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.motor_on       = rsp_motor;
  assign rsp.pattern_active = rsp_active;
  assign rsp.step_number    = rsp_step;

endmodule

/* rtl/vps_checker.sv */
// checker: port-level assertions for the sequencer core, attached by bind
module vps_checker (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic motor_on,
  input logic pattern_active,
  input logic [vps_pkg::StepW-1:0] step_number
);
  import vps_pkg::*;

  // stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(motor_on)
      && $stable(pattern_active) && $stable(step_number))
    else $error("rsp beat changed while stalled");

  // no result right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp valid right after reset");

  // motor only runs while a pattern plays
  a_motor_active: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && motor_on |-> pattern_active)
    else $error("motor on while idle");

  // step stays within the longest table
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> step_number <= LenOne)
    else $error("step beyond table length");

  // a beat held in the pipe with a stalled result blocks new beats
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && rsp_valid && !rsp_ready) ##1 !rsp_ready |-> !cmd_ready)
    else $error("new beat taken while pipe full");

endmodule

bind vibration_pattern_sequencer_core vps_checker u_vps_checker (
  .clk            (clk),
  .rst            (rst),
  .cmd_valid      (cmd.valid),
  .cmd_ready      (cmd.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .motor_on       (rsp.motor_on),
  .pattern_active (rsp.pattern_active),
  .step_number    (rsp.step_number)
);

/* bench/tb.sv */
`timescale 1ns / 100ps
// testbench: vibration pattern sequencer checked against a cycle-free player model
module tb;
  import vps_pkg::*;

  typedef struct packed {
    logic  motor;
    logic  active;
    step_t step;
  } status_t;

  typedef struct {
    op_t         op;
    sel_t        sel;
    logic        rep;
    int unsigned count;
    logic        typed;
    status_t     want;
  } row_t;

  localparam int unsigned RandomBeats = 100;
  localparam int unsigned LongHold    = 80;
  localparam int unsigned RunLimitNs  = 8_000_000;

  logic clk;
  logic rst = 1'b1;

  vps_cmd_if cmd_ch ();
  vps_rsp_if rsp_ch ();

  vibration_pattern_sequencer_core dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // player state as the block should hold it
  logic  pl_playing;
  logic  pl_looping;
  sel_t  pl_pattern;
  step_t pl_step;
  logic  pl_level;
  wait_t pl_wait;

  status_t     expected_status[$];
  row_t        plan[$];
  int unsigned mismatches  = 0;
  int unsigned beats_sent  = 0;
  logic        no_idle     = 1'b0;
  logic        hold_status = 1'b0;

  function automatic wait_t entry_wait(sel_t sel, step_t idx);
    logic [8*WaitW-1:0] row;
    if (sel == PatOne)
      row = {10'd0, 10'd0, 10'd800, 10'd400, 10'd200, 10'd400, 10'd200, 10'd400};
    else if (sel == PatTwo)
      row = {10'd0, 10'd0, 10'd0, 10'd0, 10'd800, 10'd400, 10'd400, 10'd400};
    else
      row = {10'd0, 10'd0, 10'd0, 10'd0, 10'd800, 10'd200, 10'd200, 10'd200};
    return row[idx*WaitW +: WaitW];
  endfunction

  function automatic step_t entry_count(sel_t sel);
    if (sel == PatOne) return 3'd6;
    if (sel == PatTwo) return 3'd2;
    return 3'd4;
  endfunction

  function automatic void fire_entry();
    pl_level = ~pl_level;
    pl_wait  = entry_wait(pl_pattern, pl_step);
    pl_step  = pl_step + 3'd1;
    if (pl_step >= entry_count(pl_pattern)) begin
      if (pl_looping) begin
        pl_step  = '0;
        pl_level = 1'b1;
        pl_wait  = entry_wait(pl_pattern, '0);
      end else begin
        pl_playing = 1'b0;
        pl_level   = 1'b0;
      end
    end
  endfunction

  function automatic status_t advance_player(op_t op, sel_t sel, logic rep);
    case (op)
      OP_START: begin
        pl_playing = 1'b1;
        pl_looping = rep;
        pl_pattern = sel;
        pl_step    = '0;
        pl_level   = 1'b1;
        pl_wait    = '0;
      end
      OP_STOP: begin
        pl_playing = 1'b0;
        pl_level   = 1'b0;
      end
      OP_TICK: begin
        if (pl_playing) begin
          if (pl_wait != '0) pl_wait = pl_wait - 10'd1;
          if (pl_wait == '0) fire_entry();
        end
      end
      default: ;
    endcase
    return '{motor: pl_level, active: pl_playing, step: pl_step};
  endfunction

  task automatic send(op_t op, sel_t sel, logic rep, logic typed, status_t want);
    int unsigned gap;
    status_t     got;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid          <= 1'b1;
    cmd_ch.operation      <= op;
    cmd_ch.pattern_select <= sel;
    cmd_ch.repeat_mode    <= rep;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    got = advance_player(op, sel, rep);
    expected_status.push_back(typed ? want : got);
    beats_sent++;
  endtask

  task automatic lower_valid();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    lower_valid();
    while (expected_status.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(op_t op, sel_t sel, logic rep, int unsigned count, logic typed,
                         logic motor, logic active, step_t step);
    row_t r;
    r.op    = op;
    r.sel   = sel;
    r.rep   = rep;
    r.count = count;
    r.typed = typed;
    r.want  = '{motor: motor, active: active, step: step};
    plan.push_back(r);
  endtask

  // status sink with random and long stalls
  initial begin
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_status) begin
        rsp_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_status = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    status_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected beat motor_on %b pattern_active %b step_number %0d",
                 $time, rsp_ch.motor_on, rsp_ch.pattern_active, rsp_ch.step_number);
        mismatches++;
      end else begin
        want = expected_status.pop_front();
        if (rsp_ch.motor_on !== want.motor) begin
          $display("%0t: motor_on expected %b actual %b", $time, want.motor, rsp_ch.motor_on);
          mismatches++;
        end
        if (rsp_ch.pattern_active !== want.active) begin
          $display("%0t: pattern_active expected %b actual %b",
                   $time, want.active, rsp_ch.pattern_active);
          mismatches++;
        end
        if (rsp_ch.step_number !== want.step) begin
          $display("%0t: step_number expected %0d actual %0d",
                   $time, want.step, rsp_ch.step_number);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(RunLimitNs);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int unsigned first_random;
    int unsigned run;
    int unsigned pick;
    cmd_ch.valid          = 1'b0;
    cmd_ch.operation      = OP_TICK;
    cmd_ch.pattern_select = '0;
    cmd_ch.repeat_mode    = 1'b0;
    pl_playing = 1'b0;
    pl_looping = 1'b0;
    pl_pattern = '0;
    pl_step    = '0;
    pl_level   = 1'b0;
    pl_wait    = '0;

    // directed: idle cases, a single-play end, a wrap, restarts
    add_row(OP_TICK,  2'd0, 1'b0, 1,    1'b1, 1'b0, 1'b0, 3'd0);
    add_row(OP_STOP,  2'd0, 1'b0, 1,    1'b1, 1'b0, 1'b0, 3'd0);
    add_row(OP_NONE,  2'd3, 1'b1, 1,    1'b1, 1'b0, 1'b0, 3'd0);
    add_row(OP_START, 2'd2, 1'b0, 1,    1'b1, 1'b1, 1'b1, 3'd0);
    add_row(OP_TICK,  2'd0, 1'b0, 1,    1'b1, 1'b0, 1'b1, 3'd1);
    add_row(OP_TICK,  2'd3, 1'b1, 400,  1'b1, 1'b0, 1'b0, 3'd2);
    add_row(OP_TICK,  2'd1, 1'b1, 1,    1'b1, 1'b0, 1'b0, 3'd2);
    add_row(OP_START, 2'd3, 1'b1, 1,    1'b1, 1'b1, 1'b1, 3'd0);
    add_row(OP_NONE,  2'd0, 1'b0, 1,    1'b1, 1'b1, 1'b1, 3'd0);
    add_row(OP_TICK,  2'd2, 1'b0, 601,  1'b1, 1'b1, 1'b1, 3'd0);
    // after the wrap the wait comes from the first entry, not the last
    add_row(OP_TICK,  2'd0, 1'b0, 200,  1'b1, 1'b0, 1'b1, 3'd1);
    add_row(OP_STOP,  2'd3, 1'b1, 1,    1'b1, 1'b0, 1'b0, 3'd1);
    add_row(OP_START, 2'd1, 1'b1, 1,    1'b1, 1'b1, 1'b1, 3'd0);
    add_row(OP_TICK,  2'd0, 1'b0, 1,    1'b1, 1'b0, 1'b1, 3'd1);
    add_row(OP_STOP,  2'd0, 1'b0, 1,    1'b1, 1'b0, 1'b0, 3'd1);
    add_row(OP_START, 2'd1, 1'b0, 1,    1'b0, 1'b0, 1'b0, 3'd0);
    add_row(OP_TICK,  2'd2, 1'b0, 5,    1'b0, 1'b0, 1'b0, 3'd0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      for (int unsigned k = 0; k < plan[i].count; k++)
        send(plan[i].op, plan[i].sel, plan[i].rep,
             plan[i].typed && (k == plan[i].count - 1), plan[i].want);
    end

    // long status stall while commands keep coming, then a full drain
    no_idle     = 1'b1;
    hold_status = 1'b1;
    repeat (24) send(OP_TICK, sel_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     1'b0, '0);
    no_idle = 1'b0;
    drain();

    first_random = beats_sent;
    while (beats_sent - first_random < RandomBeats) begin
      no_idle = ($urandom_range(0, 5) == 0);
      pick    = $urandom_range(0, 9);
      if (pick < 7) begin
        send(OP_START, sel_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0, '0);
        run = $urandom_range(1, 24);
        repeat (run) send(OP_TICK, sel_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          1'b0, '0);
        if ($urandom_range(0, 2) == 0)
          send(OP_STOP, sel_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end else begin
        repeat ($urandom_range(1, 8))
          send(op_t'($urandom_range(0, 3)), sel_t'($urandom_range(0, 3)),
               1'($urandom_range(0, 1)), 1'b0, '0);
      end
      if ($urandom_range(0, 4) == 0) drain();
    end

    no_idle = 1'b0;
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
